// ----- rtl/ssqe_pkg.sv -----
// ----------------------------------------------------------------------------
// ssqe_pkg
// Shared types and constants of the sorted sample quantile engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ssqe_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int PROB_W      = 17;
  localparam int QV_W        = 32;
  localparam int FRAC_W      = 17;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUANT = 2'd1;
  localparam logic [1:0] CMD_ECDF  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_PROB  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [PROB_W-1:0]      probability;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [QV_W-1:0] quantile_value;
    logic [CNT_W-1:0]       at_or_below_count;
    logic [FRAC_W-1:0]      ecdf_fraction;
    logic [CNT_W-1:0]       stored_count;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture input item
    logic scan_clr;   // reset scan pointer
    logic scan_take;  // evaluate read data against the key
    logic shift_init; // start shifting from the top
    logic shift_rd;   // read entry at shift pointer - 1
    logic shift_wr;   // write read data at shift pointer, pointer--
    logic ins_wr;     // write the sample at the scan position
    logic cnt_inc;
    logic cnt_clr;
    logic q_rd_lo;    // read entry lo
    logic q_rd_hi;    // read entry lo+1
    logic q_cap_a;
    logic q_cap_b;
    logic q_mul;      // first product stage
    logic q_sum;
    logic div_init;
    logic div_step;
    logic res_load;   // build result
  } ssqe_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       prob_bad;
    logic       scan_stop;  // pointer at count or entry > key
    logic       shift_done; // shift pointer equals scan position
    logic       div_done;
  } ssqe_sts_t;
endpackage
`default_nettype wire

// ----- rtl/ssqe_if.sv -----
// ----------------------------------------------------------------------------
// ssqe_in_if / ssqe_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface ssqe_in_if;
  logic valid;
  logic ready;
  ssqe_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ssqe_out_if;
  logic valid;
  logic ready;
  ssqe_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/ssqe_ram.sv -----
// ----------------------------------------------------------------------------
// ssqe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ssqe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/ssqe_datapath.sv -----
// ----------------------------------------------------------------------------
// ssqe_datapath
// Sorted store, scan pointer, interpolation and ecdf divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ssqe_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ssqe_pkg::in_item_t   in_item,
  input  wire ssqe_pkg::ssqe_cmd_t  cmd,
  output ssqe_pkg::ssqe_sts_t       sts,
  output ssqe_pkg::out_item_t       res
);
  localparam int AW = ssqe_pkg::ADDR_W;
  localparam int CW = ssqe_pkg::CNT_W;
  localparam int SB = ssqe_pkg::SAMPLE_BITS;
  localparam int IW = ssqe_pkg::PROB_W + CW;  // p*(n-1) width
  localparam int DW = CW + 16;                // dividend width

  // saturation limits of the interpolated sum
  localparam logic signed [SB+18:0] QV_HI = (SB+19)'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SB+18:0] QV_LO = (SB+19)'(-64'sh0000_0000_8000_0000);

  ssqe_pkg::in_item_t item_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;     // scan / shift pointer
  logic [CW-1:0] pos_r;     // insertion position or ecdf count
  logic [IW-1:0] idx_r;
  logic signed [SB-1:0] a_r, b_r;
  logic signed [SB+17:0] pa_r, pb_r;
  logic signed [SB+18:0] sum_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [$clog2(DW+1)-1:0] dstep_r;
  ssqe_pkg::out_item_t res_r, res_nxt;

  // RAM port selection
  logic          we;
  logic [AW-1:0] addr;
  logic [SB-1:0] wdata, rdata;
  logic [CW-1:0] lo, lo_c;
  logic [16:0]   frac;
  logic          use_b;

  assign lo_c = (idx_r[IW-1:16] >= {1'b0, count_r}) ? CW'(count_r - 1'b1)
                                                    : CW'(idx_r[IW-1:16]);
  assign lo   = lo_c;
  assign frac = {1'b0, idx_r[15:0]};
  assign use_b = (idx_r[15:0] != 16'd0) && (CW'(lo + 1'b1) < count_r);

  always_comb begin
    we    = 1'b0;
    addr  = ptr_r[AW-1:0];
    wdata = rdata;
    if (cmd.shift_wr) begin
      we = 1'b1;
    end else if (cmd.ins_wr) begin
      we    = 1'b1;
      addr  = pos_r[AW-1:0];
      wdata = item_r.sample_value;
    end else if (cmd.shift_rd) begin
      addr = AW'(ptr_r - 1'b1);
    end else if (cmd.q_rd_lo) begin
      addr = lo[AW-1:0];
    end else if (cmd.q_rd_hi) begin
      addr = AW'(lo + 1'b1);
    end
  end

  ssqe_ram #(.WIDTH(SB), .DEPTH(ssqe_pkg::MAX_SAMPLES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // status to controller
  assign sts.cmd        = item_r.cmd;
  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r >= CW'(ssqe_pkg::MAX_SAMPLES));
  assign sts.prob_bad   = (item_r.probability > 17'd65536);
  assign sts.scan_stop  = (ptr_r >= count_r);
  assign sts.shift_done = (ptr_r == pos_r);
  assign sts.div_done   = (dstep_r == '0);
  assign res = res_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
    // scan: entry read last cycle sits on rdata
    if (cmd.scan_clr) begin
      ptr_r <= '0;
      pos_r <= '0;
    end else if (cmd.scan_take) begin
      if ($signed(rdata) <= item_r.sample_value) begin
        pos_r <= ptr_r + 1'b1;
        ptr_r <= ptr_r + 1'b1;
      end else begin
        ptr_r <= count_r;  // stop: sorted, no later match
      end
    end
    if (cmd.shift_init) ptr_r <= count_r;
    if (cmd.shift_wr)   ptr_r <= ptr_r - 1'b1;
    if (cmd.latch) idx_r <= IW'(in_item.probability) * IW'(count_r - 1'b1);
    if (cmd.q_cap_a) a_r <= rdata;
    if (cmd.q_cap_b) b_r <= use_b ? rdata : a_r;
    if (cmd.q_mul) begin
      pa_r <= $signed({1'b0, use_b ? 17'd65536 - frac : 17'd65536}) * a_r;
      pb_r <= $signed({1'b0, use_b ? frac : 17'd0}) * b_r;
    end
    if (cmd.q_sum) sum_r <= pa_r + pb_r;
    // restoring divider, one quotient bit per cycle
    if (cmd.div_init) begin
      rem_r   <= '0;
      quo_r   <= {pos_r, 16'd0};
      dstep_r <= ($clog2(DW+1))'(DW);
    end else if (cmd.div_step) begin
      if ({rem_r[DW-2:0], quo_r[DW-1]} >= DW'(count_r)) begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]} - DW'(count_r);
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
      dstep_r <= dstep_r - 1'b1;
    end
  end

  // result build
  always_comb begin
    res_nxt = '0;
    res_nxt.stored_count = count_r;
    unique case (item_r.cmd)
      ssqe_pkg::CMD_LOAD: begin
        if (sts.full) res_nxt.status = ssqe_pkg::ST_FULL;
        else res_nxt.stored_count = count_r + 1'b1;
      end
      ssqe_pkg::CMD_QUANT: begin
        if (sts.empty) res_nxt.status = ssqe_pkg::ST_EMPTY;
        else if (sts.prob_bad) res_nxt.status = ssqe_pkg::ST_PROB;
        else if (sum_r > QV_HI) res_nxt.quantile_value = 32'sh7FFFFFFF;
        else if (sum_r < QV_LO) res_nxt.quantile_value = 32'sh80000000;
        else res_nxt.quantile_value = sum_r[ssqe_pkg::QV_W-1:0];
      end
      ssqe_pkg::CMD_ECDF: begin
        if (!sts.empty) begin
          res_nxt.at_or_below_count = pos_r;
          res_nxt.ecdf_fraction     = quo_r[ssqe_pkg::FRAC_W-1:0];
        end
      end
      default: res_nxt.stored_count = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/ssqe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssqe_ctrl
// Sequencer for load, quantile, ecdf and clear transactions.
// ----------------------------------------------------------------------------
`default_nettype none
module ssqe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire ssqe_pkg::ssqe_sts_t sts,
  output ssqe_pkg::ssqe_cmd_t      cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;  // read entry at pointer
  localparam logic [3:0] S_STAKE = 4'd3;  // compare
  localparam logic [3:0] S_SHINI = 4'd4;
  localparam logic [3:0] S_SHRD  = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_QLO   = 4'd8;
  localparam logic [3:0] S_QHI   = 4'd9;
  localparam logic [3:0] S_QCB   = 4'd10;
  localparam logic [3:0] S_QMUL  = 4'd11;
  localparam logic [3:0] S_QSUM  = 4'd12;
  localparam logic [3:0] S_DIV   = 4'd13;
  localparam logic [3:0] S_RES   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.latch    = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_DISP;
      end
      S_DISP: begin
        unique case (sts.cmd)
          ssqe_pkg::CMD_LOAD:  state_nxt = sts.full ? S_RES : S_SRD;
          ssqe_pkg::CMD_QUANT: state_nxt = (sts.empty || sts.prob_bad) ? S_RES : S_QLO;
          ssqe_pkg::CMD_ECDF:  state_nxt = sts.empty ? S_RES : S_SRD;
          default: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_RES;
          end
        endcase
      end
      S_SRD: begin
        if (sts.scan_stop)
          state_nxt = (sts.cmd == ssqe_pkg::CMD_LOAD) ? S_SHINI : S_DIV;
        else state_nxt = S_STAKE;
        if (sts.scan_stop && sts.cmd != ssqe_pkg::CMD_LOAD) cmd.div_init = 1'b1;
      end
      S_STAKE: begin
        cmd.scan_take = 1'b1;
        state_nxt     = S_SRD;
      end
      S_SHINI: begin
        cmd.shift_init = 1'b1;
        state_nxt      = S_SHRD;
      end
      S_SHRD: begin
        if (sts.shift_done) state_nxt = S_INS;
        else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHRD;
      end
      S_INS: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_RES;
      end
      S_QLO: begin
        cmd.q_rd_lo = 1'b1;
        state_nxt   = S_QHI;
      end
      S_QHI: begin
        cmd.q_rd_hi = 1'b1;
        cmd.q_cap_a = 1'b1;
        state_nxt   = S_QCB;
      end
      S_QCB: begin
        cmd.q_cap_b = 1'b1;
        state_nxt   = S_QMUL;
      end
      S_QMUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = S_QSUM;
      end
      S_QSUM: begin
        cmd.q_sum = 1'b1;
        state_nxt = S_RES;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_RES;
        else cmd.div_step = 1'b1;
      end
      S_RES: begin
        cmd.res_load = 1'b1;
        if (sts.cmd == ssqe_pkg::CMD_LOAD && !sts.full) cmd.cnt_inc = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/sorted_sample_quantile_engine_core.sv -----
// ----------------------------------------------------------------------------
// sorted_sample_quantile_engine_core
// Insertion-sorted sample store with quantile and ecdf queries.
// ----------------------------------------------------------------------------
// One transaction at a time; the result is held until taken. A load scans
// the store from the bottom, reading and comparing each entry at or below
// the sample and the first larger entry, if any, and then shifts each entry
// above the insertion point up by one; an ecdf query scans the same way and
// then runs a 27-step restoring divider; a quantile query reads the two
// neighbouring entries, weights them and sums them; clear, a load into a
// full store, a query on an empty store and a quantile query with a bad
// probability go straight to the result.
`default_nettype none
module sorted_sample_quantile_engine_core (
  input  wire logic clk,
  input  wire logic rst_n,
  ssqe_in_if.sink   in_ch,
  ssqe_out_if.source out_ch
);
  ssqe_pkg::ssqe_cmd_t cmd;
  ssqe_pkg::ssqe_sts_t sts;

  ssqe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  ssqe_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch.payload),
    .cmd(cmd), .sts(sts), .res(out_ch.payload)
  );
endmodule
`default_nettype wire
